/* hw/rtl/ftiu_pkg.sv */
// ftiu_pkg: shared types, codes and constants of the frame time integrator
// used by the top level, the divider and the bench; no dependencies

package ftiu_pkg;

  // default store depth, one entry per pixel
  localparam int NUM_PIXELS_DEFAULT = 16384;

  // width of the signed ratio numerator and denominator
  localparam int NUM_W   = 35;
  // width of the signed Q.24 gap ratio
  localparam int RATIO_W = 32;
  // divider pipeline depth, from divider input to registered ratio
  localparam int DIV_LAT = 33;

  // result status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NEG_DUR = 2'd1;
  localparam logic [1:0] STATUS_EQ_MID  = 2'd2;

  // configuration register indexes
  localparam logic CFG_TIMES_PRESENT = 1'b0;
  localparam logic CFG_PIXEL_COUNT   = 1'b1;

  // register reset values
  localparam logic [14:0] PIXEL_COUNT_RESET = 15'd16384;

  typedef struct packed {
    logic [13:0]        pixel_index;
    logic signed [31:0] sample_value;
    logic [31:0]        frame_start;
    logic [31:0]        frame_stop;
    logic [31:0]        frame_middle;
    logic               first_frame;
    logic               final_frame;
  } in_item_t;

  typedef struct packed {
    logic [13:0]        pixel_index_out;
    logic signed [63:0] integral_value;
    logic [1:0]         status;
    logic               integral_final;
  } out_item_t;

endpackage

/* hw/rtl/frame_time_integrator_unit.sv */
// frame_time_integrator_unit: top level of the per-pixel frame time integrator
// depends on ftiu_pkg, ftiu_ram and ftiu_div

// The block takes one pixel sample per cycle while in_ready is high and
// returns one result per sample, in order: two input stages reduce the index
// to a store slot, the gap ratio divider runs 33 stages (a set-up stage, one
// per quotient bit, then clamp and sign), then three multiply and
// saturating-add stages and the output register follow. The accumulator and
// previous-sample stores are read near the end of the divider and written as
// the result enters the output register. A sample whose slot matches a sample
// still in flight is held at the second input stage until that sample has
// written back, so a pixel that recurs while its last sample is in flight
// stalls the input. Stores are not cleared: a pixel is opened by a sample
// with first_frame set.

module frame_time_integrator_unit
  import ftiu_pkg::*;
#(
  parameter int NUM_PIXELS = NUM_PIXELS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_write,
  input  logic      cfg_index,
  input  logic [14:0] cfg_data,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int AW = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
  localparam int RW = 29;
  localparam logic [RW-1:0] RECIP = RW'((64'd1 << 28) / NUM_PIXELS);
  localparam logic [20:0]   NPX   = 21'(NUM_PIXELS);
  localparam logic signed [63:0] ACC_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] ACC_MIN = {1'b1, {63{1'b0}}};
  localparam logic signed [41:0] Y_MAX   = 42'sd2147483647;
  localparam logic signed [41:0] Y_MIN   = -42'sd2147483648;

  typedef struct packed {
    logic [13:0]        idx;
    logic signed [31:0] val;
    logic signed [32:0] dur;
    logic signed [32:0] gap;
    logic               first;
    logic               neg;
    logic               use_gap;
    logic [1:0]         status;
    logic               fin;
  } ctx_t;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? ACC_MIN : ACC_MAX;
    end
    return s[63:0];
  endfunction

  // configuration and frame time registers
  logic        times_present;
  logic [14:0] pixel_count;
  logic [31:0] prev_end, prev_mid;

  // handshake control
  logic en, front_en, accept, hazard;

  // input stage
  logic                     a_valid;
  ctx_t                     a_ctx;
  logic [42:0]              a_prod;
  logic signed [NUM_W-1:0]  a_num, a_den;

  // slot stage
  logic                     b_valid;
  ctx_t                     b_ctx;
  logic [AW-1:0]            b_slot;
  logic signed [NUM_W-1:0]  b_num, b_den;

  // divider shadow line
  logic          c_valid [0:DIV_LAT-1];
  ctx_t          c_ctx   [0:DIV_LAT-1];
  logic [AW-1:0] c_slot  [0:DIV_LAT-1];

  // arithmetic stages
  logic               p1_valid, p2_valid, p3_valid;
  ctx_t               p1_ctx, p2_ctx, p3_ctx;
  logic [AW-1:0]      p1_slot, p2_slot, p3_slot;
  logic signed [63:0] p1_m, p1_fterm, p1_acc;
  logic signed [31:0] p1_prev;
  logic signed [31:0] p2_y;
  logic signed [63:0] p2_acc1, p3_acc1, p3_gterm;

  // input decode
  ctx_t                    i_ctx;
  logic signed [32:0]      i_gap;
  logic                    i_gap_pos, i_eq;
  logic [42:0]             i_prod;
  logic signed [NUM_W-1:0] i_num, i_den;

  // slot reduction
  logic [20:0] qn, rem0, rem;

  // divider and stores
  logic signed [RATIO_W-1:0] ratio;
  logic [63:0]               acc_rd;
  logic [31:0]               prev_rd;
  logic                      wr_en;
  logic signed [63:0]        acc2;

  // stage arithmetic
  logic signed [32:0] diff;
  logic signed [64:0] mul_m, mul_f, mul_g;
  logic signed [63:0] m_adj, m_trunc;
  logic signed [41:0] y_sum;

  assign en       = !out_valid || out_ready;
  assign front_en = en && !(b_valid && hazard);
  assign in_ready = front_en;
  assign accept   = in_valid && in_ready;

  // decode of the incoming item
  always_comb begin
    i_ctx.idx   = in_item.pixel_index;
    i_ctx.val   = in_item.sample_value;
    i_ctx.first = in_item.first_frame;
    i_ctx.dur   = times_present ?
                  $signed({1'b0, in_item.frame_stop}) - $signed({1'b0, in_item.frame_start})
                  : 33'sd256;
    i_ctx.neg   = times_present && (in_item.frame_stop < in_item.frame_start);
    i_gap       = $signed({1'b0, in_item.frame_start}) - $signed({1'b0, prev_end});
    i_gap_pos   = times_present && !in_item.first_frame && !i_gap[32] && (i_gap != 33'sd0);
    i_eq        = (in_item.frame_middle == prev_mid);
    i_ctx.gap     = i_gap;
    i_ctx.use_gap = i_gap_pos && !i_eq && !i_ctx.neg;
    if (i_ctx.neg) begin
      i_ctx.status = STATUS_NEG_DUR;
    end else if (i_gap_pos && i_eq) begin
      i_ctx.status = STATUS_EQ_MID;
    end else begin
      i_ctx.status = STATUS_OK;
    end
    i_ctx.fin = !i_ctx.neg && in_item.final_frame;
    i_num = $signed({3'b0, in_item.frame_start}) + $signed({3'b0, prev_end})
          - $signed({2'b0, prev_mid, 1'b0});
    i_den = $signed({2'b0, in_item.frame_middle, 1'b0}) - $signed({2'b0, prev_mid, 1'b0});
    i_prod = {29'd0, in_item.pixel_index} * {14'd0, RECIP};
  end

  // configuration writes and frame time latch
  always_ff @(posedge clk) begin
    if (rst) begin
      times_present <= 1'b1;
      pixel_count   <= PIXEL_COUNT_RESET;
      prev_end      <= '0;
      prev_mid      <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_TIMES_PRESENT: times_present <= cfg_data[0];
          CFG_PIXEL_COUNT:   pixel_count   <= cfg_data;
          default:           ;
        endcase
      end
      if (accept && (pixel_count != 15'd0)
          && ({1'b0, in_item.pixel_index} == pixel_count - 15'd1)) begin
        prev_end <= in_item.frame_stop;
        prev_mid <= in_item.frame_middle;
      end
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (front_en) begin
      a_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (front_en) begin
      a_ctx  <= i_ctx;
      a_prod <= i_prod;
      a_num  <= i_num;
      a_den  <= i_den;
    end
  end

  // index modulo store depth by reciprocal and one correction
  assign qn   = 21'({6'd0, a_prod[42:28]} * NPX);
  assign rem0 = {7'd0, a_ctx.idx} - qn;
  assign rem  = (rem0 >= NPX) ? rem0 - NPX : rem0;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (front_en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (front_en) begin
      b_ctx  <= a_ctx;
      b_slot <= AW'(rem);
      b_num  <= a_num;
      b_den  <= a_den;
    end
  end

  // same-slot interlock against every item not yet written back
  always_comb begin
    hazard = (p1_valid && p1_slot == b_slot) || (p2_valid && p2_slot == b_slot)
          || (p3_valid && p3_slot == b_slot);
    for (int i = 0; i < DIV_LAT; i++) begin
      hazard = hazard || (c_valid[i] && c_slot[i] == b_slot);
    end
  end

  // shadow line alongside the divider
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        c_valid[i] <= 1'b0;
      end
    end else if (en) begin
      c_valid[0] <= b_valid && front_en;
      for (int i = 1; i < DIV_LAT; i++) begin
        c_valid[i] <= c_valid[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_ctx[0]  <= b_ctx;
      c_slot[0] <= b_slot;
      for (int i = 1; i < DIV_LAT; i++) begin
        c_ctx[i]  <= c_ctx[i-1];
        c_slot[i] <= c_slot[i-1];
      end
    end
  end

  ftiu_div u_div (
    .clk   (clk),
    .en    (en),
    .num   (b_num),
    .den   (b_den),
    .ratio (ratio)
  );

  // per-pixel stores, read as the ratio completes
  ftiu_ram #(.W(64), .DEPTH(NUM_PIXELS), .AW(AW)) u_acc_ram (
    .clk     (clk),
    .rd_en   (en),
    .rd_addr (c_slot[DIV_LAT-2]),
    .rd_data (acc_rd),
    .wr_en   (wr_en),
    .wr_addr (p3_slot),
    .wr_data (acc2)
  );

  ftiu_ram #(.W(32), .DEPTH(NUM_PIXELS), .AW(AW)) u_prev_ram (
    .clk     (clk),
    .rd_en   (en),
    .rd_addr (c_slot[DIV_LAT-2]),
    .rd_data (prev_rd),
    .wr_en   (wr_en),
    .wr_addr (p3_slot),
    .wr_data (p3_ctx.val)
  );

  // interpolation product and frame term
  assign diff  = $signed({c_ctx[DIV_LAT-1].val[31], c_ctx[DIV_LAT-1].val})
               - $signed({prev_rd[31], prev_rd});
  assign mul_m = diff * ratio;
  assign mul_f = c_ctx[DIV_LAT-1].dur * c_ctx[DIV_LAT-1].val;

  // truncate toward zero, add previous sample, saturate to q16.16
  assign m_adj   = p1_m + (p1_m[63] ? 64'sd16777215 : 64'sd0);
  assign m_trunc = m_adj >>> 24;
  assign y_sum   = $signed({{10{p1_prev[31]}}, p1_prev}) + m_trunc[41:0];

  // gap term and final sum
  assign mul_g = p2_ctx.gap * p2_y;
  assign acc2  = p3_ctx.use_gap ? sat_add(p3_acc1, p3_gterm) : p3_acc1;
  assign wr_en = en && p3_valid && !p3_ctx.neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid  <= 1'b0;
      p2_valid  <= 1'b0;
      p3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      p1_valid  <= c_valid[DIV_LAT-1];
      p2_valid  <= p1_valid;
      p3_valid  <= p2_valid;
      out_valid <= p3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_ctx    <= c_ctx[DIV_LAT-1];
      p1_slot   <= c_slot[DIV_LAT-1];
      p1_m      <= mul_m[63:0];
      p1_fterm  <= mul_f[63:0];
      p1_prev   <= prev_rd;
      p1_acc    <= acc_rd;

      p2_ctx    <= p1_ctx;
      p2_slot   <= p1_slot;
      if (y_sum > Y_MAX) begin
        p2_y <= 32'sh7FFF_FFFF;
      end else if (y_sum < Y_MIN) begin
        p2_y <= 32'sh8000_0000;
      end else begin
        p2_y <= y_sum[31:0];
      end
      p2_acc1   <= p1_ctx.first ? p1_fterm : sat_add(p1_acc, p1_fterm);

      p3_ctx    <= p2_ctx;
      p3_slot   <= p2_slot;
      p3_gterm  <= mul_g[63:0];
      p3_acc1   <= p2_acc1;

      out_item.pixel_index_out <= p3_ctx.idx;
      out_item.integral_value  <= p3_ctx.neg ? 64'sd0 : acc2;
      out_item.status          <= p3_ctx.status;
      out_item.integral_final  <= p3_ctx.fin;
    end
  end

endmodule

/* hw/rtl/ftiu_ram.sv */
// ftiu_ram: simple dual-port synchronous memory, one write and one read port
// read data registered; no dependencies

module ftiu_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data
);

  logic [W-1:0] mem [0:DEPTH-1];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/ftiu_div.sv */
// ftiu_div: pipelined signed divider for the gap ratio, one quotient bit a stage
// result clamped to +-2^30; depends on ftiu_pkg

module ftiu_div
  import ftiu_pkg::*;
(
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [NUM_W-1:0]   num,
  input  logic signed [NUM_W-1:0]   den,
  output logic signed [RATIO_W-1:0] ratio
);

  localparam int QW = 31;  // quotient bits
  localparam int MW = 34;  // magnitude width of operands and remainder
  localparam int LW = 7;   // numerator bits shifted in below the initial remainder
  localparam int SH = 24;  // numerator scale
  localparam logic [QW-1:0] QLIM = QW'(32'h4000_0000);

  logic [NUM_W-1:0] num_neg, den_neg;
  logic [MW-1:0]    num_mag, den_mag;
  logic [MW-1:0]    num_top;

  logic [MW-1:0] rem  [0:QW];
  logic [MW-1:0] dm   [0:QW];
  logic [LW-1:0] nlo  [0:QW];
  logic [QW-1:0] quo  [0:QW];
  logic          sgn  [0:QW];
  logic          ovf  [0:QW];

  logic [QW-1:0] q_mag, q_clamp;

  // operand magnitudes
  assign num_neg = -num;
  assign den_neg = -den;
  assign num_mag = num[NUM_W-1] ? num_neg[MW-1:0] : num[MW-1:0];
  assign den_mag = den[NUM_W-1] ? den_neg[MW-1:0] : den[MW-1:0];
  assign num_top = {{LW{1'b0}}, num_mag[MW-1:LW]};

  // set-up stage: overflow check and initial remainder
  always_ff @(posedge clk) begin
    if (en) begin
      ovf[0]  <= (num_top >= den_mag);
      rem[0]  <= (num_top >= den_mag) ? '0 : num_top;
      dm[0]   <= den_mag;
      nlo[0]  <= num_mag[LW-1:0];
      quo[0]  <= '0;
      sgn[0]  <= num[NUM_W-1] ^ den[NUM_W-1];
    end
  end

  // one quotient bit per stage, msb first
  for (genvar k = 1; k <= QW; k++) begin : g_bit
    localparam int B = QW - k;
    logic          bit_in;
    logic [MW:0]   shifted;
    logic          take;
    logic [QW-1:0] q_next;

    if (B >= SH) begin : g_num
      assign bit_in = nlo[k-1][B-SH];
    end else begin : g_zero
      assign bit_in = 1'b0;
    end

    assign shifted = {rem[k-1], bit_in};
    assign take    = (shifted >= {1'b0, dm[k-1]});
    assign q_next  = quo[k-1] | (QW'(take) << B);

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]    <= take ? MW'(shifted - {1'b0, dm[k-1]}) : shifted[MW-1:0];
        quo[k]    <= q_next;
        dm[k]     <= dm[k-1];
        nlo[k]    <= nlo[k-1];
        sgn[k]    <= sgn[k-1];
        ovf[k]    <= ovf[k-1];
      end
    end
  end

  // clamp and sign
  assign q_mag   = ovf[QW] ? '1 : quo[QW];
  assign q_clamp = (q_mag > QLIM) ? QLIM : q_mag;

  always_ff @(posedge clk) begin
    if (en) begin
      ratio <= sgn[QW] ? -$signed({1'b0, q_clamp}) : $signed({1'b0, q_clamp});
    end
  end

endmodule

/* bench/tb_frame_time_integrator_unit.sv */
// tb_frame_time_integrator_unit: self-checking bench for the frame time integrator
// depends on ftiu_pkg and frame_time_integrator_unit; runs a directed table, then
// frame-shaped random streams under several register settings
`timescale 1ns / 100ps

module tb_frame_time_integrator_unit;
  import ftiu_pkg::*;

  localparam int  DEPTH       = 16384;
  localparam int  CYCLE_LIMIT = 1000000;
  localparam int  DRAIN       = 60;
  localparam longint RATIO_MAX = 64'sd1 << 30;
  localparam longint RATIO_UNIT = 64'sd1 << 24;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cfg_write = 1'b0;
  logic      cfg_index = CFG_TIMES_PRESENT;
  logic [14:0] cfg_data = '0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  frame_time_integrator_unit dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  always #5 clk = ~clk;

  // predictor state
  longint      acc_store [DEPTH];
  logic [31:0] last_sample [DEPTH];
  bit          opened [DEPTH];
  logic [31:0] latched_end = '0;
  logic [31:0] latched_mid = '0;
  logic        times_on = 1'b1;
  logic [14:0] frame_pixels = PIXEL_COUNT_RESET;

  out_item_t pending_results[$];
  int  mismatches = 0;
  int  cycles = 0;
  bit  calm = 0;

  // run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic longint sat_sum(longint a, longint b);
    longint s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63])
      s = a[63] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    return s;
  endfunction

  // value interpolated at the gap midpoint, Q16.16 saturated
  function automatic longint gap_midpoint_value(longint prev, longint cur, longint start,
                                                longint mid);
    longint num, den, r, y;
    num = start + longint'(latched_end) - 2 * longint'(latched_mid);
    den = 2 * (mid - longint'(latched_mid));
    r = (num * RATIO_UNIT) / den;
    if (r > RATIO_MAX) r = RATIO_MAX;
    if (r < -RATIO_MAX) r = -RATIO_MAX;
    y = prev + ((cur - prev) * r) / RATIO_UNIT;
    if (y > 64'sd2147483647) y = 64'sd2147483647;
    if (y < -64'sd2147483648) y = -64'sd2147483648;
    return y;
  endfunction

  // expected result of one sample, updating the predictor state
  function automatic out_item_t integrate_sample(in_item_t it);
    out_item_t o;
    longint dur, val, start, stop, mid, acc, gap;
    int slot;
    slot = int'(it.pixel_index) % DEPTH;
    val = longint'($signed(it.sample_value));
    start = longint'(it.frame_start);
    stop = longint'(it.frame_stop);
    mid = longint'(it.frame_middle);
    dur = times_on ? stop - start : 64'sd256;
    acc = 0;
    o = '0;
    o.status = STATUS_OK;
    if (dur < 0) begin
      o.status = STATUS_NEG_DUR;
    end else begin
      if (it.first_frame) begin
        acc = dur * val;
      end else begin
        acc = sat_sum(acc_store[slot], dur * val);
        gap = start - longint'(latched_end);
        if (times_on && gap > 0) begin
          if (mid == longint'(latched_mid))
            o.status = STATUS_EQ_MID;
          else
            acc = sat_sum(acc, gap * gap_midpoint_value(
                longint'($signed(last_sample[slot])), val, start, mid));
        end
      end
      acc_store[slot] = acc;
      last_sample[slot] = it.sample_value;
      opened[slot] = 1;
      o.integral_final = it.final_frame;
    end
    if (frame_pixels != 0 && {1'b0, it.pixel_index} == frame_pixels - 15'd1) begin
      latched_end = it.frame_stop;
      latched_mid = it.frame_middle;
    end
    o.pixel_index_out = it.pixel_index;
    o.integral_value = acc;
    return o;
  endfunction

  // offer one item, then predict once it is taken; called just after a rising edge
  task automatic push_sample(in_item_t it, bit typed, out_item_t typed_res);
    int idle;
    out_item_t res;
    idle = calm ? 0 : $urandom_range(0, 3);
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    res = integrate_sample(it);
    pending_results.push_back(typed ? typed_res : res);
  endtask

  // result side: random back-pressure and field compare
  initial begin
    out_item_t want;
    int idle;
    @(negedge rst);
    forever begin
      idle = calm ? 0 : $urandom_range(0, 3);
      if (idle > 0) begin
        out_ready <= 1'b0;
        repeat (idle) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_item);
      end else begin
        want = pending_results.pop_front();
        if (out_item.pixel_index_out !== want.pixel_index_out ||
            out_item.integral_value !== want.integral_value ||
            out_item.status !== want.status ||
            out_item.integral_final !== want.integral_final) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p got %p", want, out_item);
        end
      end
    end
  end

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [14:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_TIMES_PRESENT) times_on = value[0];
    else frame_pixels = value;
  endtask

  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 1)) return $urandom;
    return 32'($urandom_range(0, 32'h100000)) - 32'h80000;
  endfunction

  // frames over a small pixel set with random gaps, overlaps and time faults
  task automatic stream_frames(int n);
    int count, base, k, sent, frame;
    longint cursor, start, stop, mid, prev_mid;
    in_item_t it;
    out_item_t none;
    none = '0;
    if (frame_pixels >= 1 && frame_pixels <= 16) begin
      count = frame_pixels;
      base = 0;
    end else begin
      count = 8;
      base = DEPTH - 8;
    end
    cursor = $urandom_range(0, 5000);
    prev_mid = cursor;
    sent = 0;
    frame = 0;
    while (sent < n) begin
      case ($urandom_range(0, 7))
        0: start = cursor;
        5: start = cursor - $urandom_range(1, 500);
        6: start = cursor + $urandom_range(100000, 10000000);
        default: start = cursor + $urandom_range(1, 1000);
      endcase
      if (start < 0) start = 0;
      stop = start + $urandom_range(0, 2000);
      mid = (start + stop) / 2;
      if ($urandom_range(0, 7) == 0) mid = prev_mid;
      if ($urandom_range(0, 9) == 0) stop = start - $urandom_range(1, 300);
      if (stop < 0) stop = 0;
      if (stop > 64'hF000_0000) begin
        stop = 1000;
        start = 0;
      end
      for (k = 0; k < count; k++) begin
        it.pixel_index = 14'(base + k);
        it.sample_value = pick_value();
        it.frame_start = 32'(start);
        it.frame_stop = 32'(stop);
        it.frame_middle = 32'(mid);
        // occasional stray sample anywhere in the index space
        if ($urandom_range(0, 11) == 0) begin
          it.pixel_index = 14'($urandom);
          it.frame_start = $urandom;
          it.frame_stop = $urandom;
          it.frame_middle = $urandom;
        end
        it.first_frame = (frame == 0) || !opened[it.pixel_index] ||
                         ($urandom_range(0, 19) == 0);
        it.final_frame = ($urandom_range(0, 9) == 0);
        push_sample(it, 1'b0, none);
        sent++;
      end
      cursor = stop;
      prev_mid = mid;
      frame++;
    end
  endtask

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t res;
  } stim_row_t;

  stim_row_t directed [9];
  logic [14:0] phase_pixels [7] = '{15'd4, 15'd3, 15'd1, 15'd16384, 15'd0, 15'd16384, 15'd9};
  logic        phase_times [7]  = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};

  initial begin
    int p;
    // directed rows: index, value, start, stop, mid, first, final
    directed[0] = '{'{14'd0, 32'h0001_0000, 32'd0, 32'd256, 32'd128, 1'b1, 1'b0}, 1,
                    '{14'd0, 64'h100_0000, STATUS_OK, 1'b0}};
    // negative duration leaves the pixel untouched
    directed[1] = '{'{14'd1, 32'h8000_0000, 32'd100, 32'd50, 32'd75, 1'b1, 1'b1}, 1,
                    '{14'd1, 64'd0, STATUS_NEG_DUR, 1'b0}};
    directed[2] = '{'{14'h3FFF, 32'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1,
                      1'b1}, 0, '0};
    directed[3] = '{'{14'd0, 32'd1, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0}, 0, '0};
    directed[4] = '{'{14'h3FFF, 32'h8000_0000, 32'd0, 32'hFFFF_FFFF, 32'd0, 1'b0, 1'b0}, 0, '0};
    directed[5] = '{'{14'h3FFF, 32'd5, 32'd1000, 32'd2000, 32'd1500, 1'b1, 1'b0}, 0, '0};
    // equal mids, gap skipped
    directed[6] = '{'{14'd0, 32'd2, 32'd3000, 32'd4000, 32'd1500, 1'b0, 1'b0}, 0, '0};
    // gap with interpolation
    directed[7] = '{'{14'd0, 32'hFFFF_0000, 32'd3000, 32'd3512, 32'd3256, 1'b0, 1'b1}, 0, '0};
    directed[8] = '{'{14'h3FFF, 32'hFFFF_FFFF, 32'd5000, 32'd5000, 32'd5000, 1'b0, 1'b1},
                    0, '0};

    // hold reset, then release it before the directed rows
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) push_sample(directed[i].item, directed[i].typed, directed[i].res);
    drain_results();

    for (p = 0; p < 7; p++) begin
      write_reg(CFG_TIMES_PRESENT, {14'd0, phase_times[p]});
      write_reg(CFG_PIXEL_COUNT, phase_pixels[p]);
      calm = (p == 2);
      stream_frames(250);
      calm = 0;
      drain_results();
    end

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
